// ===== design/ffr_pkg.sv =====
// Shared types and constants for the frame flip/rotate unit.
package ffr_pkg;

   localparam int PIXEL_W    = 32;
   localparam int BYTE_W     = 8;
   localparam int MAX_CHAN   = 4;
   localparam int CFG_DIM_W  = 9;
   localparam int CFG_CHAN_W = 3;
   localparam int CFG_MODE_W = 3;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CFG_DIM_W-1:0]  RESET_DIM  = CFG_DIM_W'(256);
   localparam logic [CFG_CHAN_W-1:0] RESET_CHAN = CFG_CHAN_W'(4);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic [CFG_MODE_W-1:0] {
      ORIENT_NONE    = 3'd0,
      ORIENT_MIRROR_H = 3'd1,
      ORIENT_MIRROR_V = 3'd2,
      ORIENT_ROT90   = 3'd3,
      ORIENT_ROT180  = 3'd4,
      ORIENT_ROT270  = 3'd5
   } orient_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2,
      CSR_ORIENT_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0]  frame_width;
      logic [CFG_DIM_W-1:0]  frame_height;
      logic [CFG_CHAN_W-1:0] channel_count;
      logic [CFG_MODE_W-1:0] orient_mode;
   } cfg_type;

endpackage

// ===== design/ffr_ram.sv =====
// Generic single-port RAM with registered read.
module ffr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ffr_addr_gen.sv =====
// Load and read position counters and source address generation.
module ffr_addr_gen #(
   parameter int MAX_DIM = 256,
   parameter int ADDR_W  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ffr_pkg::cfg_type     cfg,
   input  logic                 restart,
   input  logic                 step,
   input  logic                 step_read,
   output logic [ADDR_W-1:0]    addr,
   output logic                 last
);

   import ffr_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int PW = CW + DW;

   function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      if (v == '0) begin
         return DW'(1);
      end
      if (32'(v) > 32'(MAX_DIM)) begin
         return DW'(MAX_DIM);
      end
      return DW'(v);
   endfunction

   logic [ADDR_W-1:0] load_index_ff, load_index_in;
   logic [CW-1:0]     ld_col_ff, ld_col_in, ld_row_ff, ld_row_in;
   logic [CW-1:0]     out_col_ff, out_col_in, out_row_ff, out_row_in;

   logic [DW-1:0]     w_eff, h_eff, ow, oh;
   logic [CW-1:0]     w_m1, h_m1, src_c, src_r;
   logic              rot, col_end, row_end, ld_col_end, ld_row_end;
   logic [PW-1:0]     prod;
   logic [ADDR_W-1:0] read_addr;
   orient_type        mode;

   always_comb begin
      w_eff = clamp_dim(cfg.frame_width);
      h_eff = clamp_dim(cfg.frame_height);
      w_m1  = CW'(w_eff - DW'(1));
      h_m1  = CW'(h_eff - DW'(1));
      mode  = orient_type'(cfg.orient_mode);
      rot   = (mode == ORIENT_ROT90) || (mode == ORIENT_ROT270);
      ow    = rot ? h_eff : w_eff;
      oh    = rot ? w_eff : h_eff;

      col_end    = (DW'(out_col_ff) + DW'(1)) == ow;
      row_end    = (DW'(out_row_ff) + DW'(1)) == oh;
      ld_col_end = (DW'(ld_col_ff) + DW'(1)) == w_eff;
      ld_row_end = (DW'(ld_row_ff) + DW'(1)) == h_eff;

      case (mode)
         ORIENT_MIRROR_H: begin
            src_c = w_m1 - out_col_ff;
            src_r = out_row_ff;
         end
         ORIENT_MIRROR_V: begin
            src_c = out_col_ff;
            src_r = h_m1 - out_row_ff;
         end
         ORIENT_ROT90: begin
            src_c = out_row_ff;
            src_r = h_m1 - out_col_ff;
         end
         ORIENT_ROT180: begin
            src_c = w_m1 - out_col_ff;
            src_r = h_m1 - out_row_ff;
         end
         ORIENT_ROT270: begin
            src_c = w_m1 - out_row_ff;
            src_r = out_col_ff;
         end
         default: begin
            // no change, also for the two unused mode codes
            src_c = out_col_ff;
            src_r = out_row_ff;
         end
      endcase

      prod      = PW'(src_r) * PW'(w_eff);
      read_addr = ADDR_W'(prod) + ADDR_W'(src_c);
      addr      = step_read ? read_addr : load_index_ff;
      last      = col_end && row_end;
   end

   always_comb begin
      load_index_in = load_index_ff;
      ld_col_in     = ld_col_ff;
      ld_row_in     = ld_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      if (restart) begin
         load_index_in = '0;
         ld_col_in     = '0;
         ld_row_in     = '0;
         out_col_in    = '0;
         out_row_in    = '0;
      end else if (step && step_read) begin
         if (col_end) begin
            out_col_in = '0;
            out_row_in = row_end ? '0 : out_row_ff + CW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end else if (step) begin
         load_index_in = (ld_col_end && ld_row_end) ? '0 : load_index_ff + ADDR_W'(1);
         if (ld_col_end) begin
            ld_col_in = '0;
            ld_row_in = ld_row_end ? '0 : ld_row_ff + CW'(1);
         end else begin
            ld_col_in = ld_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         ld_col_ff     <= '0;
         ld_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         load_index_ff <= load_index_in;
         ld_col_ff     <= ld_col_in;
         ld_row_ff     <= ld_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
   end

endmodule

// ===== design/frame_flip_rotate_unit.sv =====
// Frame flip/rotate unit: frame store with mirrored and rotated raster readout.
//
//   channel   ports                                              direction  notes
//   request   req_valid, req_stall, req_command, req_pixel_in    in         load or read
//   response  rsp_valid, rsp_stall, rsp_pixel_out, rsp_frame_last out       one per read
//   csr       csr_wr_en, csr_index, csr_wr_data                  in         write only
//
// One request per cycle unless a held response stalls the pipe; a read's answer passes
// the address register, the frame store read register and the output register.
// The frame store has one port, so each request does at most one access there.
// Reset clears the pipeline valids and the position counters and loads the configuration defaults;
// the frame store is not cleared and holds garbage until loaded.
// A stalled response freezes the whole pipeline, so req_stall follows rsp_stall
// while a response is held.
module frame_flip_rotate_unit #(
   parameter int MAX_DIM      = 256,
   parameter int FRAME_PIXELS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_frame_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wr_data
);

   import ffr_pkg::*;

   // raster addresses reach MAX_DIM^2-1; the store may be smaller or larger
   localparam int FW = $clog2(MAX_DIM * MAX_DIM);
   localparam int AW = $clog2(FRAME_PIXELS);
   localparam int LW = (FW > AW) ? FW : AW;
   localparam logic [LW:0] STORE_END = (LW + 1)'(FRAME_PIXELS);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wr_data[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wr_data[CFG_DIM_W-1:0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wr_data[CFG_CHAN_W-1:0];
            CSR_ORIENT_MODE:   cfg_in.orient_mode   = csr_wr_data[CFG_MODE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= RESET_DIM;
         cfg_ff.frame_height  <= RESET_DIM;
         cfg_ff.channel_count <= RESET_CHAN;
         cfg_ff.orient_mode   <= ORIENT_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage 1: address register
   logic               s1_valid_ff, s1_read_ff, s1_in_range_ff, s1_last_ff;
   logic [LW-1:0]      s1_addr_ff;
   logic [PIXEL_W-1:0] s1_data_ff;

   // stage 2: store read register (inside the RAM) plus tags
   logic               s2_valid_ff, s2_zero_ff, s2_last_ff;

   // stage 3: output register
   logic               rsp_valid_ff, rsp_frame_last_ff;
   logic [PIXEL_W-1:0] rsp_pixel_out_ff, rsp_pixel_out_in;

   // whole pipeline moves unless the output holds an untaken response
   logic advance, accept, is_read;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign is_read   = cmd_type'(req_command) == CMD_READ;

   logic [LW-1:0] gen_addr;
   logic          gen_last;

   ffr_addr_gen #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (LW)
   ) u_addr_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .restart   (csr_wr_en),
      .step      (accept),
      .step_read (is_read),
      .addr      (gen_addr),
      .last      (gen_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff && s1_read_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_read_ff        <= is_read;
         s1_addr_ff        <= gen_addr;
         s1_in_range_ff    <= {1'b0, gen_addr} < STORE_END;
         s1_last_ff        <= gen_last;
         s1_data_ff        <= req_pixel_in;
         s2_zero_ff        <= !s1_in_range_ff;
         s2_last_ff        <= s1_last_ff;
         rsp_pixel_out_ff  <= rsp_pixel_out_in;
         rsp_frame_last_ff <= s2_last_ff;
      end
   end

   // frame store; loads past the store are dropped
   logic               ram_wr_en, ram_rd_en;
   logic [PIXEL_W-1:0] ram_rd_data;

   assign ram_wr_en = advance && s1_valid_ff && !s1_read_ff && s1_in_range_ff;
   assign ram_rd_en = advance && s1_valid_ff && s1_read_ff;

   ffr_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (FRAME_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (s1_addr_ff[AW-1:0]),
      .wr_data (s1_data_ff),
      .rd_data (ram_rd_data)
   );

   // byte mask from channel count, clamped to 1..4
   logic [CFG_CHAN_W-1:0] chan_eff;
   logic [PIXEL_W-1:0]    chan_mask;

   always_comb begin
      if (cfg_ff.channel_count == '0) begin
         chan_eff = CFG_CHAN_W'(1);
      end else if (cfg_ff.channel_count > CFG_CHAN_W'(MAX_CHAN)) begin
         chan_eff = CFG_CHAN_W'(MAX_CHAN);
      end else begin
         chan_eff = cfg_ff.channel_count;
      end
      for (int k = 0; k < MAX_CHAN; k++) begin
         chan_mask[k*BYTE_W +: BYTE_W] = {BYTE_W{CFG_CHAN_W'(k) < chan_eff}};
      end
      // a read past the store returns zero
      rsp_pixel_out_in = s2_zero_ff ? '0 : (ram_rd_data & chan_mask);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_out_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // a load never turns into a response
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && !s1_read_ff) |=> !s2_valid_ff)
      else $error("load request produced a response slot");

   // read data must hold while the response is stalled
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(ram_rd_data))
      else $error("store read data changed under a stalled response");

   // single store port: never a write and a read together
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read in the same cycle");

   // pipeline freezes while the output is held
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(s2_valid_ff) && $stable(s1_valid_ff)))
      else $error("pipeline moved under a stalled response");

endmodule

// ===== test/frame_flip_rotate_unit_test.sv =====
// Self-checking testbench for the frame flip/rotate unit: random loads and reads against a local predictor.
module frame_flip_rotate_unit_test;
   import ffr_pkg::*;

   // Mode codes past the defined list; the block treats both as a pass-through.
   localparam logic [CFG_MODE_W-1:0] ORIENT_SPARE_LO = 3'd6;
   localparam logic [CFG_MODE_W-1:0] ORIENT_SPARE_HI = 3'd7;

   typedef struct {
      logic [PIXEL_W-1:0] pixel_out;
      logic               frame_last;
   } pixel_result_type;

   // Orientation predictor plus the queue of pixels still owed by the block.
   class orient_scoreboard;
      localparam int unsigned MAX_SIDE = 256;
      localparam int unsigned STORE_WORDS = 65536;

      logic [PIXEL_W-1:0]    frame_mem [STORE_WORDS];
      bit                    loaded [STORE_WORDS];
      logic [CFG_DIM_W-1:0]  width_reg = RESET_DIM;
      logic [CFG_DIM_W-1:0]  height_reg = RESET_DIM;
      logic [CFG_CHAN_W-1:0] chan_reg = RESET_CHAN;
      logic [CFG_MODE_W-1:0] mode_reg = ORIENT_NONE;
      int unsigned           load_pos = 0;
      int unsigned           out_col = 0;
      int unsigned           out_row = 0;
      pixel_result_type      owed_pixels [$];
      int unsigned           mismatches = 0;
      int unsigned           checked = 0;

      function int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_SIDE) return MAX_SIDE;
         return v;
      endfunction

      function orient_type active_mode();
         return (mode_reg > ORIENT_ROT270) ? ORIENT_NONE : orient_type'(mode_reg);
      endfunction

      // Store index of the source pixel for the current output position.
      function int unsigned source_index();
         int unsigned w;
         int unsigned h;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         case (active_mode())
            ORIENT_MIRROR_H: return (w - 1 - out_col) + out_row * w;
            ORIENT_MIRROR_V: return out_col + (h - 1 - out_row) * w;
            ORIENT_ROT90:    return out_row + (h - 1 - out_col) * w;
            ORIENT_ROT180:   return (w - 1 - out_col) + (h - 1 - out_row) * w;
            ORIENT_ROT270:   return (w - 1 - out_row) + out_col * w;
            default:         return out_col + out_row * w;
         endcase
      endfunction

      function bit read_ready();
         return loaded[source_index()];
      endfunction

      function int unsigned pending();
         return owed_pixels.size();
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH:   width_reg = data;
            CSR_FRAME_HEIGHT:  height_reg = data;
            CSR_CHANNEL_COUNT: chan_reg = data[CFG_CHAN_W-1:0];
            CSR_ORIENT_MODE:   mode_reg = data[CFG_MODE_W-1:0];
            default: ;
         endcase
         // any write restarts both raster positions; store contents stay
         load_pos = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function void note_request(cmd_type cmd, logic [PIXEL_W-1:0] pixel);
         int unsigned        w;
         int unsigned        h;
         int unsigned        out_w;
         int unsigned        out_h;
         int unsigned        chans;
         bit                 turned;
         logic [PIXEL_W-1:0] keep;
         pixel_result_type   res;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         if (cmd == CMD_LOAD) begin
            frame_mem[load_pos] = pixel;
            loaded[load_pos] = 1'b1;
            load_pos = (load_pos + 1 >= w * h) ? 0 : load_pos + 1;
         end else begin
            turned = (active_mode() == ORIENT_ROT90) || (active_mode() == ORIENT_ROT270);
            out_w = turned ? h : w;
            out_h = turned ? w : h;
            chans = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHAN) ? MAX_CHAN : chan_reg;
            keep = (chans >= MAX_CHAN) ? '1 : (PIXEL_W'(1) << (BYTE_W * chans)) - 1;
            res.pixel_out = frame_mem[source_index()] & keep;
            res.frame_last = (out_col + 1 >= out_w) && (out_row + 1 >= out_h);
            owed_pixels.push_back(res);
            if (out_col + 1 >= out_w) begin
               out_col = 0;
               out_row = (out_row + 1 >= out_h) ? 0 : out_row + 1;
            end else begin
               out_col++;
            end
         end
      endfunction

      function void check_response(logic [PIXEL_W-1:0] pixel, logic last);
         pixel_result_type want;
         if (owed_pixels.size() == 0) begin
            $error("unexpected response: pixel_out %h frame_last %b", pixel, last);
            mismatches++;
            return;
         end
         want = owed_pixels.pop_front();
         if (pixel !== want.pixel_out) begin
            $error("pixel_out: expected %h, got %h", want.pixel_out, pixel);
            mismatches++;
         end
         if (last !== want.frame_last) begin
            $error("frame_last: expected %b, got %b", want.frame_last, last);
            mismatches++;
         end
         checked++;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = CMD_LOAD;
   logic [PIXEL_W-1:0]    req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_out;
   logic                  rsp_frame_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   orient_scoreboard board;
   int unsigned      requests_sent = 0;
   bit               steady = 1'b0;   // no sender gaps in this phase

   frame_flip_rotate_unit #(
      .MAX_DIM      (256),
      .FRAME_PIXELS (65536)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Offer one request, hold it until accepted, then maybe go idle for a while.
   // Gaps: mostly none, some short, rarely long.
   task automatic send_request(cmd_type cmd, logic [PIXEL_W-1:0] pixel);
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         gap = 0;
      else if (roll < 90)
         gap = $urandom_range(1, 3);
      else if (roll < 98)
         gap = $urandom_range(4, 10);
      else
         gap = $urandom_range(20, 50);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pixel_in <= pixel;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, pixel);
      requests_sent++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // csr_wr_en is left high so back-to-back writes need no second assignment per edge;
   // the caller drops it after the last write.
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      board.set_register(idx, data);
   endtask

   // New frame setup. The sender stops, every owed pixel has to come back, and a
   // few extra cycles let trailing loads clear the three-stage pipe before the write.
   // Upper data bits of the narrow registers are random; the block must ignore them.
   task automatic apply_config(logic [CFG_DIM_W-1:0] width, logic [CFG_DIM_W-1:0] height,
                               logic [CFG_CHAN_W-1:0] chans, logic [CFG_MODE_W-1:0] mode);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
      write_register(CSR_CHANNEL_COUNT, {6'($urandom()), chans});
      write_register(CSR_ORIENT_MODE, {6'($urandom()), mode});
      csr_wr_en <= 1'b0;
   endtask

   // Mix of loads and reads. A read whose source pixel was never loaded since
   // reset becomes a load instead, so the load pointer walks ahead of the readout.
   task automatic run_phase(int unsigned count, int unsigned read_pct);
      repeat (count) begin
         if ($urandom_range(1, 100) <= read_pct && board.read_ready())
            send_request(CMD_READ, $urandom());
         else
            send_request(CMD_LOAD, $urandom());
      end
   endtask

   // Response checker: sampled at the edge, before any update from that edge lands.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_pixel_out, rsp_frame_last);
   end

   // Receiver back-pressure. Once, well into the run, it holds off for a long
   // stretch so the pipe fills and req_stall has to rise; otherwise random runs
   // of ready and stalled cycles, mostly short.
   initial begin : receiver_backpressure
      int unsigned roll;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         roll = $urandom_range(0, 99);
         if (!long_hold_done && board.checked >= 120) begin
            rsp_stall <= 1'b1;
            repeat (96) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (roll < 50) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (roll < 90) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (roll < 98) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(4, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned roll;
      logic [CFG_MODE_W-1:0] mode;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 frame, all bytes, straight readout; pixel extremes
      apply_config(9'd2, 9'd2, 3'd4, ORIENT_NONE);
      send_request(CMD_LOAD, 32'h0000_0000);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_LOAD, 32'hA5A5_A5A5);
      send_request(CMD_LOAD, 32'h5A5A_5A5A);
      repeat (4) send_request(CMD_READ, 32'hFFFF_FFFF);

      // zero sizes act as a 1x1 frame, zero channels keep byte 0, top spare mode
      // passes through; two reads in a row wrap the one-pixel frame
      apply_config(9'd0, 9'd0, 3'd0, ORIENT_SPARE_HI);
      send_request(CMD_LOAD, 32'hFFFF_FFFF);
      send_request(CMD_READ, 32'h0000_0000);
      send_request(CMD_READ, 32'hFFFF_FFFF);

      // store survives register writes: reread the 2x2 frame with no new loads,
      // channel count above four, lower spare mode, then rotated by 180 with 3 bytes
      apply_config(9'd2, 9'd2, 3'd7, ORIENT_SPARE_LO);
      repeat (4) send_request(CMD_READ, $urandom());
      apply_config(9'd2, 9'd2, 3'd3, ORIENT_ROT180);
      repeat (4) send_request(CMD_READ, $urandom());

      // widest frames: width register all ones clamps to the maximum, then an
      // exact-maximum height turned on its side
      apply_config(9'd511, 9'd1, 3'd4, ORIENT_MIRROR_H);
      run_phase(600, 90);
      apply_config(9'd1, 9'd256, 3'd2, ORIENT_ROT270);
      run_phase(600, 60);

      // small random frames over every mode; phases often end mid-frame,
      // so the next register write also restarts a partial frame
      while (requests_sent < 1950) begin
         steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         mode = (roll < 90) ? 3'($urandom_range(ORIENT_NONE, ORIENT_ROT270))
                            : 3'($urandom_range(ORIENT_SPARE_LO, ORIENT_SPARE_HI));
         apply_config(9'($urandom_range(0, 12)), 9'($urandom_range(0, 12)),
                      3'($urandom_range(0, 7)), mode);
         run_phase($urandom_range(20, 90), $urandom_range(30, 70));
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin : watchdog
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
